// ===== hdl/tdh_pkg.sv =====
package tdh_pkg;

	localparam int unsigned ZW      = 16;
	localparam int unsigned CEIL_W  = 26;
	localparam int unsigned MAG_W   = 13;
	localparam int unsigned GAIN_W  = 12;
	localparam int unsigned DRIVE_W = 14;
	localparam int unsigned FRAC_W  = 13;
	localparam int unsigned PROD_W  = MAG_W + GAIN_W;
	localparam int unsigned SCL_W   = PROD_W - FRAC_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = CEIL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd3;

	localparam logic [CEIL_W-1:0] CEIL_RST  = 26'd58042456;
	localparam logic [MAG_W-1:0]  START_RST = 13'd2048;
	localparam logic [MAG_W-1:0]  STOP_RST  = 13'd1229;
	localparam logic [GAIN_W-1:0] GAIN_RST  = 12'd1000;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

endpackage

// ===== hdl/tdh_if.sv =====
interface tdh_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [tdh_pkg::ZW-1:0]   accel_z;
	logic signed [tdh_pkg::ZW-1:0]   accel_y;
	modport source (output valid, accel_z, accel_y, input ready);
	modport sink   (input valid, accel_z, accel_y, output ready);
endinterface

interface tdh_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [tdh_pkg::DRIVE_W-1:0] drive;
	logic [1:0]                        dir_state;
	modport source (output valid, drive, dir_state, input ready);
	modport sink   (input valid, drive, dir_state, output ready);
endinterface

interface tdh_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [tdh_pkg::CFG_IDX_W-1:0]       index;
	logic [tdh_pkg::CFG_DATA_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tilt_drive_with_hysteresis.sv =====
// Tilt drive: each accelerometer word (Z, Y at 8192 counts per g) gives one result word
// holding the drive value and the latched direction. The lateral magnitude
// floor(sqrt(ceiling - z*z)) comes out of a bit-serial square root that yields one root bit
// per cycle; an accepted word goes through the load, root, multiply and output states,
// and the next input word is taken only once the block is back in idle; a finished
// result waits in the output register while the next word is already being worked on, and
// a word whose result finds that register still full waits until it is read. Configuration
// writes are taken in any cycle and must only happen while the block is idle.
module tilt_drive_with_hysteresis (
	input  logic       clk,
	input  logic       arst_n,
	tdh_cfg_if.sink    cfg,
	tdh_in_if.sink     sample,
	tdh_out_if.source  result
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_ROOT = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [tdh_pkg::CEIL_W-1:0] ceil_q;
	logic [tdh_pkg::MAG_W-1:0]  start_q;
	logic [tdh_pkg::MAG_W-1:0]  stop_q;
	logic [tdh_pkg::GAIN_W-1:0] gain_q;

	logic [tdh_pkg::MAG_W-1:0]  prev_q;
	tdh_pkg::dir_t              dir_q;

	logic [30:0]                zsq_q;
	logic                       ypos_q;
	logic [tdh_pkg::MAG_W-1:0]  mag_q;
	logic [tdh_pkg::PROD_W-1:0] prod_q;

	logic                              out_valid_q;
	logic signed [tdh_pkg::DRIVE_W-1:0] drive_q;
	logic [1:0]                        dir_out_q;

	logic [tdh_pkg::ZW:0]       zabs;
	logic [30:0]                zsq_full;
	logic [tdh_pkg::CEIL_W-1:0] radicand;
	logic                       root_done;
	logic [tdh_pkg::MAG_W-1:0]  root;
	logic [tdh_pkg::SCL_W-1:0]  scaled;
	logic [tdh_pkg::DRIVE_W-1:0] drive_d;
	logic                       accept;
	logic                       out_free;

	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		zabs = sample.accel_z[tdh_pkg::ZW-1]
			? (tdh_pkg::ZW+1)'(-{sample.accel_z[tdh_pkg::ZW-1], sample.accel_z})
			: {1'b0, sample.accel_z};
		zsq_full = 31'(zabs) * 31'(zabs);
		radicand = (zsq_q >= 31'(ceil_q)) ? '0
			: ceil_q - zsq_q[tdh_pkg::CEIL_W-1:0];
		scaled = prod_q[tdh_pkg::PROD_W-1:tdh_pkg::FRAC_W];
		unique case (dir_q)
			tdh_pkg::DIR_POS: drive_d = tdh_pkg::DRIVE_W'(scaled);
			tdh_pkg::DIR_NEG: drive_d = tdh_pkg::DRIVE_W'(-{2'b00, scaled});
			default:          drive_d = '0;
		endcase
	end

	tdh_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_LOAD),
		.radicand (radicand),
		.done     (root_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q  <= tdh_pkg::CEIL_RST;
			start_q <= tdh_pkg::START_RST;
			stop_q  <= tdh_pkg::STOP_RST;
			gain_q  <= tdh_pkg::GAIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tdh_pkg::CFG_CEIL:  ceil_q  <= cfg.data;
				tdh_pkg::CFG_START: start_q <= cfg.data[tdh_pkg::MAG_W-1:0];
				tdh_pkg::CFG_STOP:  stop_q  <= cfg.data[tdh_pkg::MAG_W-1:0];
				tdh_pkg::CFG_GAIN:  gain_q  <= cfg.data[tdh_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			dir_q       <= tdh_pkg::DIR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_ROOT;
				ST_ROOT: if (root_done) state_q <= ST_MUL;
				ST_MUL: begin
					priority if (mag_q > start_q && prev_q <= start_q)
						dir_q <= ypos_q ? tdh_pkg::DIR_POS : tdh_pkg::DIR_NEG;
					else if (mag_q < stop_q && prev_q >= stop_q)
						dir_q <= tdh_pkg::DIR_NONE;
					else
						dir_q <= dir_q;
					prev_q  <= mag_q;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			zsq_q  <= zsq_full;
			ypos_q <= !sample.accel_y[tdh_pkg::ZW-1] && (sample.accel_y != '0);
		end
		if (state_q == ST_ROOT && root_done)
			mag_q <= root;
		if (state_q == ST_MUL)
			prod_q <= tdh_pkg::PROD_W'(mag_q) * tdh_pkg::PROD_W'(gain_q);
		if (state_q == ST_OUT && out_free) begin
			drive_q   <= drive_d;
			dir_out_q <= dir_q;
		end
	end

	assign cfg.ready        = 1'b1;
	assign sample.ready     = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.dir_state = dir_out_q;

endmodule

// ===== hdl/tdh_sqrt.sv =====
module tdh_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tdh_pkg::CEIL_W-1:0]    radicand,
	output logic                          done,
	output logic [tdh_pkg::MAG_W-1:0]     root
);

	localparam int unsigned RW = tdh_pkg::MAG_W + 3;
	localparam logic [3:0]  LAST = 4'(tdh_pkg::MAG_W - 1);

	logic [tdh_pkg::CEIL_W-1:0] rad_q;
	logic [tdh_pkg::MAG_W:0]    rem_q;
	logic [tdh_pkg::MAG_W-1:0]  root_q;
	logic [3:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic [RW-1:0] rem_d;
	logic          ge;

	// two radicand bits in, one root bit out per cycle
	always_comb begin
		rem_sh = {rem_q, rad_q[tdh_pkg::CEIL_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_d  = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[tdh_pkg::CEIL_W-3:0], 2'b00};
			rem_q  <= rem_d[tdh_pkg::MAG_W:0];
			root_q <= {root_q[tdh_pkg::MAG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned N_PHASES       = 10;
	localparam int unsigned PHASE_WORDS    = 110;
	localparam int unsigned PRESSURE_PHASE = 5;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned IDLE_LIMIT     = 2000;
	localparam int unsigned END_TAIL       = 40;

	localparam logic [tdh_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = tdh_pkg::CFG_GAIN + 1'b1;
	localparam logic [tdh_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

	typedef enum {ROW_WORD, ROW_REG} row_kind_t;
	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_t;

	typedef struct {
		logic signed [tdh_pkg::DRIVE_W-1:0] drive;
		tdh_pkg::dir_t                      dir;
	} drive_word_t;

	typedef struct {
		row_kind_t                          kind;
		logic signed [tdh_pkg::ZW-1:0]      z;
		logic signed [tdh_pkg::ZW-1:0]      y;
		bit                                 typed;
		drive_word_t                        known;
		logic [tdh_pkg::CFG_IDX_W-1:0]      idx;
		logic [tdh_pkg::CFG_DATA_W-1:0]     data;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tdh_cfg_if cfg_if();
	tdh_in_if  sample_if();
	tdh_out_if result_if();

	tilt_drive_with_hysteresis DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.sample (sample_if),
		.result (result_if)
	);

	// predictor copy of registers and state
	logic [tdh_pkg::CEIL_W-1:0] ceil_sq;
	logic [tdh_pkg::MAG_W-1:0]  start_lvl;
	logic [tdh_pkg::MAG_W-1:0]  stop_lvl;
	logic [tdh_pkg::GAIN_W-1:0] gain_k;
	logic [tdh_pkg::MAG_W-1:0]  last_mag;
	tdh_pkg::dir_t              held_dir;

	drive_word_t due_results[$];
	drive_word_t due;
	stim_row_t   plan[$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          hold_reqs = 0;
	rx_mode_t    rx_mode = RX_RANDOM;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [tdh_pkg::MAG_W-1:0] floor_root(
		input logic [tdh_pkg::CEIL_W-1:0] v);
		logic [tdh_pkg::MAG_W-1:0] r;
		logic [tdh_pkg::MAG_W-1:0] t;
		r = '0;
		for (int b = tdh_pkg::MAG_W - 1; b >= 0; b--) begin
			t = r;
			t[b] = 1'b1;
			if (longint'(t) * longint'(t) <= longint'(v))
				r = t;
		end
		return r;
	endfunction

	function automatic drive_word_t tilt_step(input logic signed [tdh_pkg::ZW-1:0] z,
		input logic signed [tdh_pkg::ZW-1:0] y);
		longint                     zsq;
		logic [tdh_pkg::MAG_W-1:0]  mag;
		logic [tdh_pkg::PROD_W-1:0] prod;
		int                         s;
		drive_word_t                w;
		zsq = longint'(z) * longint'(z);
		if (zsq >= longint'(ceil_sq))
			mag = '0;
		else
			mag = floor_root(tdh_pkg::CEIL_W'(longint'(ceil_sq) - zsq));
		if (mag > start_lvl && last_mag <= start_lvl)
			held_dir = (y > 0) ? tdh_pkg::DIR_POS : tdh_pkg::DIR_NEG;
		else if (mag < stop_lvl && last_mag >= stop_lvl)
			held_dir = tdh_pkg::DIR_NONE;
		last_mag = mag;
		prod = tdh_pkg::PROD_W'(mag) * tdh_pkg::PROD_W'(gain_k);
		s = int'(prod[tdh_pkg::PROD_W-1:tdh_pkg::FRAC_W]);
		w.dir = held_dir;
		case (held_dir)
			tdh_pkg::DIR_POS: w.drive = tdh_pkg::DRIVE_W'(s);
			tdh_pkg::DIR_NEG: w.drive = tdh_pkg::DRIVE_W'(-s);
			default:          w.drive = '0;
		endcase
		return w;
	endfunction

	function automatic void set_model_reg(input logic [tdh_pkg::CFG_IDX_W-1:0] idx,
		input logic [tdh_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			tdh_pkg::CFG_CEIL:  ceil_sq   = data[tdh_pkg::CEIL_W-1:0];
			tdh_pkg::CFG_START: start_lvl = data[tdh_pkg::MAG_W-1:0];
			tdh_pkg::CFG_STOP:  stop_lvl  = data[tdh_pkg::MAG_W-1:0];
			tdh_pkg::CFG_GAIN:  gain_k    = data[tdh_pkg::GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void add_known(input logic signed [tdh_pkg::ZW-1:0] z,
		input logic signed [tdh_pkg::ZW-1:0] y,
		input logic signed [tdh_pkg::DRIVE_W-1:0] drive, input tdh_pkg::dir_t dir);
		stim_row_t r;
		r.kind        = ROW_WORD;
		r.z           = z;
		r.y           = y;
		r.typed       = 1'b1;
		r.known.drive = drive;
		r.known.dir   = dir;
		r.idx         = '0;
		r.data        = '0;
		plan.push_back(r);
	endfunction

	function automatic void add_word(input logic signed [tdh_pkg::ZW-1:0] z,
		input logic signed [tdh_pkg::ZW-1:0] y);
		add_known(z, y, '0, tdh_pkg::DIR_NONE);
		plan[$].typed = 1'b0;
	endfunction

	function automatic void add_reg(input logic [tdh_pkg::CFG_IDX_W-1:0] idx,
		input logic [tdh_pkg::CFG_DATA_W-1:0] data);
		add_known('0, '0, '0, tdh_pkg::DIR_NONE);
		plan[$].kind = ROW_REG;
		plan[$].idx  = idx;
		plan[$].data = data;
	endfunction

	function automatic logic signed [tdh_pkg::ZW-1:0] pick_z();
		logic [tdh_pkg::MAG_W-1:0]     root;
		logic [tdh_pkg::MAG_W-1:0]     lvl;
		logic [tdh_pkg::MAG_W-1:0]     m;
		logic signed [tdh_pkg::ZW-1:0] z;
		int                            t;
		root = floor_root(ceil_sq);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: z = -32768;
					1: z = 32767;
					2: z = 0;
					3: z = -1;
					default: z = 1;
				endcase
			end
			1, 2: z = tdh_pkg::ZW'($urandom());
			default: begin
				// aim at a magnitude, mostly around the two levels
				if ($urandom_range(0, 2) == 0) begin
					m = tdh_pkg::MAG_W'($urandom_range(0, root));
				end else begin
					lvl = $urandom_range(0, 1) ? start_lvl : stop_lvl;
					t = int'(lvl) + int'($urandom_range(0, 6)) - 3;
					if (t < 0)
						t = 0;
					if (t > root)
						t = root;
					m = tdh_pkg::MAG_W'(t);
				end
				z = {3'b000, floor_root(ceil_sq -
					tdh_pkg::CEIL_W'(m) * tdh_pkg::CEIL_W'(m))};
				if ($urandom_range(0, 1))
					z = -z;
			end
		endcase
		return z;
	endfunction

	function automatic logic signed [tdh_pkg::ZW-1:0] pick_y();
		logic signed [tdh_pkg::ZW-1:0] y;
		case ($urandom_range(0, 7))
			0: y = 0;
			1: begin
				case ($urandom_range(0, 3))
					0: y = -32768;
					1: y = 32767;
					2: y = 1;
					default: y = -1;
				endcase
			end
			default: y = tdh_pkg::ZW'($urandom());
		endcase
		return y;
	endfunction

	task automatic send_word(input logic signed [tdh_pkg::ZW-1:0] z,
		input logic signed [tdh_pkg::ZW-1:0] y, input bit typed, input drive_word_t known);
		drive_word_t w;
		sample_if.valid   <= 1'b1;
		sample_if.accel_z <= z;
		sample_if.accel_y <= y;
		do @(posedge clk); while (sample_if.ready !== 1'b1);
		w = tilt_step(z, y);
		due_results.push_back(typed ? known : w);
	endtask

	task automatic write_reg(input logic [tdh_pkg::CFG_IDX_W-1:0] idx,
		input logic [tdh_pkg::CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		set_model_reg(idx, data);
	endtask

	task automatic wait_drained();
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_phase_regs(input int ph);
		logic [tdh_pkg::CEIL_W-1:0]     c;
		logic [tdh_pkg::MAG_W-1:0]      root;
		logic [tdh_pkg::MAG_W-1:0]      st;
		logic [tdh_pkg::MAG_W-1:0]      sp;
		logic [tdh_pkg::GAIN_W-1:0]     g;
		logic [tdh_pkg::CFG_DATA_W-1:0] junk;
		if (ph == 3)
			c = '0;
		else begin
			case (ph % 3)
				0: c = '1;
				1: c = tdh_pkg::CEIL_RST;
				default: c = tdh_pkg::CEIL_W'($urandom_range(1, 2 ** tdh_pkg::CEIL_W - 1));
			endcase
		end
		root = floor_root(c);
		st = (ph == 1) ? '0 : (ph == 2) ? '1 : tdh_pkg::MAG_W'($urandom_range(0, root));
		sp = (ph == 1) ? '1 : (ph == 2) ? '0 : tdh_pkg::MAG_W'($urandom_range(0, root));
		g  = (ph == 0) ? '1 : (ph == 4) ? '0 : tdh_pkg::GAIN_W'($urandom());
		// odd phases carry junk above the register width
		junk = tdh_pkg::CFG_DATA_W'($urandom());
		junk[tdh_pkg::MAG_W-1:0] = '0;
		if (ph % 2 == 0)
			junk = '0;
		write_reg(tdh_pkg::CFG_CEIL, c);
		write_reg(tdh_pkg::CFG_START, junk | st);
		write_reg(tdh_pkg::CFG_STOP, junk | sp);
		write_reg(tdh_pkg::CFG_GAIN, junk | g);
		if (ph % 4 == 1)
			write_reg(tdh_pkg::CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
				tdh_pkg::CFG_DATA_W'($urandom()));
		cfg_if.valid <= 1'b0;
	endtask

	// result side: stall pattern, with an occasional long hold-off
	initial begin
		int holds_done;
		int stall_left;
		int rx_tick;
		holds_done = 0;
		stall_left = 0;
		rx_tick = 0;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				result_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				case (rx_mode)
					RX_ALWAYS: result_if.ready <= 1'b1;
					RX_RANDOM: result_if.ready <= ($urandom_range(0, 9) < 6);
					RX_PERIODIC: begin
						rx_tick++;
						result_if.ready <= (rx_tick % 7) < 3;
					end
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							result_if.ready <= 1'b0;
						end else begin
							result_if.ready <= 1'b1;
							if ($urandom_range(0, 3) == 0)
								stall_left = $urandom_range(1, 40);
						end
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			if (due_results.size() == 0) begin
				$display("%0t: result word with none due, drive %0d dir %0d",
					$time, result_if.drive, result_if.dir_state);
				errors++;
			end else begin
				due = due_results.pop_front();
				if (result_if.drive !== due.drive) begin
					$display("%0t: drive mismatch, expected %0d, got %0d",
						$time, due.drive, result_if.drive);
					errors++;
				end
				if (result_if.dir_state !== due.dir) begin
					$display("%0t: dir_state mismatch, expected %0d, got %0d",
						$time, due.dir, result_if.dir_state);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (sample_if.valid && sample_if.ready) ||
			(result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int          words;
		int          burst;
		int          gap;
		bit          no_gaps;
		bit          reg_phase;
		drive_word_t blank;

		arst_n            = 1'b0;
		sample_if.valid   = 1'b0;
		sample_if.accel_z = '0;
		sample_if.accel_y = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = tdh_pkg::CFG_CEIL;
		cfg_if.data       = '0;
		ceil_sq           = tdh_pkg::CEIL_RST;
		start_lvl         = tdh_pkg::START_RST;
		stop_lvl          = tdh_pkg::STOP_RST;
		gain_k            = tdh_pkg::GAIN_RST;
		last_mag          = '0;
		held_dir          = tdh_pkg::DIR_NONE;
		blank.drive       = '0;
		blank.dir         = tdh_pkg::DIR_NONE;

		// reset levels
		add_known(32767, 100, 0, tdh_pkg::DIR_NONE);
		add_known(-32768, -1, 0, tdh_pkg::DIR_NONE);
		add_known(0, 1, 929, tdh_pkg::DIR_POS);
		add_word(0, 0);
		add_known(32767, 5, 0, tdh_pkg::DIR_NONE);
		add_known(0, 0, -929, tdh_pkg::DIR_NEG);     // zero Y latches negative
		add_known(-32768, 0, 0, tdh_pkg::DIR_NONE);
		add_known(0, -32768, -929, tdh_pkg::DIR_NEG);
		add_word(0, 32767);
		add_word(6963, 1);
		add_word(7400, 1);
		add_word(7500, -1);
		add_word(-7560, 1);
		add_word(7400, -5);
		add_word(-7000, 7);
		// full-scale ceiling and gain
		add_reg(tdh_pkg::CFG_CEIL, '1);
		add_reg(tdh_pkg::CFG_GAIN, 4095);
		add_known(0, 1, 4094, tdh_pkg::DIR_POS);
		add_known(-32768, 1, 0, tdh_pkg::DIR_NONE);
		add_known(0, -1, -4094, tdh_pkg::DIR_NEG);
		// start never reached, stop never crossed, zero gain, unused indexes
		add_reg(tdh_pkg::CFG_START, '1);
		add_reg(tdh_pkg::CFG_STOP, 0);
		add_reg(CFG_UNUSED_LO, 0);
		add_reg(CFG_UNUSED_HI, '1);
		add_reg(tdh_pkg::CFG_GAIN, 0);
		add_word(32767, 1);
		add_word(0, 1);
		add_reg(tdh_pkg::CFG_CEIL, 0);
		add_word(0, -1);
		// start level below stop level
		add_reg(tdh_pkg::CFG_CEIL, tdh_pkg::CEIL_RST);
		add_reg(tdh_pkg::CFG_START, 1000);
		add_reg(tdh_pkg::CFG_STOP, 3000);
		add_reg(tdh_pkg::CFG_GAIN, 1000);
		add_word(0, 1);
		add_word(7400, 1);
		add_word(7000, -1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		reg_phase = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WORD) begin
				if (reg_phase) begin
					cfg_if.valid <= 1'b0;
					reg_phase = 1'b0;
				end
				send_word(plan[i].z, plan[i].y, plan[i].typed, plan[i].known);
			end else begin
				if (!reg_phase) begin
					sample_if.valid <= 1'b0;
					wait_drained();
					reg_phase = 1'b1;
				end
				write_reg(plan[i].idx, plan[i].data);
			end
		end
		sample_if.valid <= 1'b0;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			load_phase_regs(ph);
			rx_mode <= (ph == 0) ? RX_ALWAYS : rx_mode_t'($urandom_range(1, 3));
			no_gaps = (ph == 0 || ph == PRESSURE_PHASE);
			if (ph == PRESSURE_PHASE)
				hold_reqs <= hold_reqs + 1;
			words = 0;
			while (words < PHASE_WORDS) begin
				burst = no_gaps ? PHASE_WORDS : $urandom_range(1, 12);
				for (int k = 0; k < burst && words < PHASE_WORDS; k++) begin
					send_word(pick_z(), pick_y(), 1'b0, blank);
					words++;
				end
				if (!no_gaps && words < PHASE_WORDS) begin
					gap = $urandom_range(1, 40);
					sample_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			sample_if.valid <= 1'b0;
		end

		wait_drained();
		repeat (END_TAIL) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tdh_pkg.sv
hdl/tdh_if.sv
hdl/tdh_sqrt.sv
hdl/tilt_drive_with_hysteresis.sv
dv/testbench.sv
